/* rtl/core/wol_pkg.sv */
package wol_pkg;

  // Field widths fixed by the item formats.
  localparam int FRAC_W     = 16;
  localparam int BASE_W     = 25;
  localparam int AMP_W      = 16;
  localparam int PITCH_W    = 16;
  localparam int PITCH_FRAC = 12;
  localparam int INC_W      = BASE_W + PITCH_W - PITCH_FRAC;
  localparam int IDX_W      = 9;
  localparam int SMP_W      = 16;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = BASE_W;

  localparam logic [CFG_IDX_W-1:0] CFG_BASE_INC  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_AMPLITUDE = 1'b1;

  localparam logic [BASE_W-1:0] BASE_INC_RESET  = '0;
  localparam logic [AMP_W-1:0]  AMPLITUDE_RESET = 16'd32768;

  localparam logic CMD_RENDER = 1'b0;
  localparam logic CMD_WRITE  = 1'b1;

  typedef struct packed {
    logic                     cmd;
    logic [IDX_W-1:0]         table_index;
    logic signed [SMP_W-1:0]  table_value;
    logic [PITCH_W-1:0]       pitch_factor;
    logic signed [SMP_W-1:0]  mix_in;
  } in_item_t;

  typedef struct packed {
    logic signed [SMP_W-1:0]  sample_out;
    logic                     saturated;
  } out_item_t;

  // One classified job between front and back.
  typedef struct packed {
    logic                     is_write;
    logic [IDX_W-1:0]         index;
    logic signed [SMP_W-1:0]  value;
    logic [PITCH_W-1:0]       pitch;
    logic signed [SMP_W-1:0]  mix;
  } job_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ_B,
    S_INTERP,
    S_SCALE,
    S_OUT,
    S_WRAP
  } back_state_t;

endpackage

/* rtl/core/wol_front.sv */
module wol_front #(
  parameter int TABLE_LENGTH = 512
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  wol_pkg::in_item_t in_data,
  output logic              job_valid,
  output wol_pkg::job_t     job,
  input  logic              job_pop
);
  import wol_pkg::*;

  localparam logic [16:0] TL = 17'(TABLE_LENGTH);

  job_t       q_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       keep;
  logic       push;
  job_t       entry;

  assign in_ready  = (count_r != 2'd2);
  assign job_valid = (count_r != 2'd0);
  assign job       = q_r[rd_ptr_r];

  // Writes aimed past the end of the table are consumed and dropped here.
  always_comb begin
    keep = (in_data.cmd == CMD_RENDER) || (17'(in_data.table_index) < TL);
    push = in_valid && in_ready && keep;
    entry.is_write = (in_data.cmd == CMD_WRITE);
    entry.index    = in_data.table_index;
    entry.value    = in_data.table_value;
    entry.pitch    = in_data.pitch_factor;
    entry.mix      = in_data.mix_in;
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = job_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(job_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= entry;
    end
  end

endmodule

/* rtl/core/wol_wrap.sv */
module wol_wrap #(
  parameter int TABLE_LENGTH = 512
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        start,
  input  logic [((($clog2(TABLE_LENGTH) + 16) > wol_pkg::INC_W) ?
                 ($clog2(TABLE_LENGTH) + 16) : wol_pkg::INC_W):0] sum_in,
  output logic                                        busy,
  output logic [$clog2(TABLE_LENGTH) + 15:0]          result
);
  import wol_pkg::*;

  localparam int AW    = $clog2(TABLE_LENGTH);
  localparam int PH_W  = AW + FRAC_W;
  localparam int SUM_W = ((PH_W > INC_W) ? PH_W : INC_W) + 1;
  localparam int X_W   = SUM_W - FRAC_W;
  localparam int RCP_W = X_W + 1;
  localparam int SH    = X_W + AW;
  localparam longint unsigned RCP_FULL = (64'd1 << SH) / TABLE_LENGTH;
  localparam logic [RCP_W-1:0] RCP = RCP_W'(RCP_FULL);
  localparam logic [X_W-1:0]   TL  = X_W'(TABLE_LENGTH);

  logic [X_W-1:0]       x_r, x_nxt;
  logic [FRAC_W-1:0]    low_r, low_nxt;
  logic [X_W-1:0]       q_r, q_nxt;
  logic [X_W-1:0]       rem_r, rem_nxt;
  logic [PH_W-1:0]      res_r, res_nxt;
  logic [2:0]           stg_r, stg_nxt;
  logic [X_W+RCP_W-1:0] prod;
  logic [X_W-1:0]       rem_fix;

  assign busy   = |stg_r;
  assign result = res_r;

  // The span is a whole number of entries, so only the integer part is reduced.
  // The reciprocal estimate of the quotient is at most one short; one compare and
  // subtract on the remainder finishes the job.
  always_comb begin
    x_nxt   = x_r;
    low_nxt = low_r;
    q_nxt   = q_r;
    rem_nxt = rem_r;
    res_nxt = res_r;
    prod    = x_r * RCP;
    rem_fix = (rem_r >= TL) ? rem_r - TL : rem_r;
    stg_nxt = {stg_r[1:0], start};
    if (start) begin
      x_nxt   = sum_in[SUM_W-1:FRAC_W];
      low_nxt = sum_in[FRAC_W-1:0];
    end
    if (stg_r[0]) begin
      q_nxt = X_W'(prod >> SH);
    end
    if (stg_r[1]) begin
      rem_nxt = x_r - X_W'(q_r * TL);
    end
    if (stg_r[2]) begin
      res_nxt = {rem_fix[AW-1:0], low_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_r <= 3'b000;
    end else begin
      stg_r <= stg_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r   <= x_nxt;
    low_r <= low_nxt;
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    res_r <= res_nxt;
  end

endmodule

/* rtl/core/wol_back.sv */
module wol_back #(
  parameter int TABLE_LENGTH = 512
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          job_valid,
  input  wol_pkg::job_t                 job,
  output logic                          job_pop,
  input  logic [wol_pkg::BASE_W-1:0]    base_inc,
  input  logic [wol_pkg::AMP_W-1:0]     amplitude,
  output logic                          out_valid,
  input  logic                          out_ready,
  output wol_pkg::out_item_t            out_data
);
  import wol_pkg::*;

  localparam int AW    = $clog2(TABLE_LENGTH);
  localparam int PH_W  = AW + FRAC_W;
  localparam int SUM_W = ((PH_W > INC_W) ? PH_W : INC_W) + 1;
  localparam int MUL_W = BASE_W + PITCH_W;
  localparam logic [AW-1:0] LAST = AW'(TABLE_LENGTH - 1);

  logic signed [SMP_W-1:0] mem [TABLE_LENGTH];
  logic signed [SMP_W-1:0] rd_data_r;
  logic [AW-1:0]           rd_addr;
  logic                    mem_we;
  logic [AW-1:0]           wr_addr;
  logic [16:0]             idx_ext;

  back_state_t             state_r, state_nxt;
  logic [PH_W-1:0]         phase_r, phase_nxt;
  job_t                    job_r, job_nxt;
  logic signed [SMP_W-1:0] a_r, a_nxt;
  logic [MUL_W-1:0]        mul_r, mul_nxt;
  logic signed [SMP_W-1:0] interp_r, interp_nxt;
  logic signed [17:0]      scaled_r, scaled_nxt;
  logic                    out_valid_r, out_valid_nxt;
  out_item_t               out_data_r, out_data_nxt;

  logic [AW-1:0]           pos, pos_next;
  logic [FRAC_W-1:0]       frac;
  logic signed [16:0]      diff;
  logic signed [33:0]      lerp_prod;
  logic signed [17:0]      lerp_sum;
  logic signed [32:0]      amp_prod;
  logic signed [18:0]      mix_sum;
  logic [SUM_W-1:0]        wrap_sum;
  logic                    wrap_start;
  logic                    wrap_busy;
  logic [PH_W-1:0]         wrap_result;

  wol_wrap #(
    .TABLE_LENGTH (TABLE_LENGTH)
  ) u_wrap (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (wrap_start),
    .sum_in (wrap_sum),
    .busy   (wrap_busy),
    .result (wrap_result)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    pos      = phase_r[PH_W-1:FRAC_W];
    frac     = phase_r[FRAC_W-1:0];
    pos_next = (pos == LAST) ? '0 : pos + 1'b1;
    idx_ext  = 17'(job.index);
    wr_addr  = idx_ext[AW-1:0];
    // a + floor((b - a) * frac / 2^16) equals the two-weight sum shifted down.
    diff      = 17'(rd_data_r) - 17'(a_r);
    lerp_prod = diff * $signed({1'b0, frac});
    lerp_sum  = 18'(a_r) + 18'(lerp_prod >>> FRAC_W);
    amp_prod  = interp_r * $signed({1'b0, amplitude});
    mix_sum   = 19'(scaled_r) + 19'(job_r.mix);
    wrap_sum  = SUM_W'(phase_r) + SUM_W'(mul_r[MUL_W-1:PITCH_FRAC]);
  end

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    job_nxt       = job_r;
    a_nxt         = a_r;
    mul_nxt       = mul_r;
    interp_nxt    = interp_r;
    scaled_nxt    = scaled_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    job_pop       = 1'b0;
    mem_we        = 1'b0;
    rd_addr       = pos;
    wrap_start    = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (job_valid) begin
          job_pop = 1'b1;
          if (job.is_write) begin
            mem_we = 1'b1;
          end else begin
            job_nxt   = job;
            state_nxt = S_READ_B;
          end
        end
      end
      S_READ_B: begin
        rd_addr   = pos_next;
        a_nxt     = rd_data_r;
        mul_nxt   = base_inc * job_r.pitch;
        state_nxt = S_INTERP;
      end
      S_INTERP: begin
        interp_nxt = lerp_sum[SMP_W-1:0];
        wrap_start = 1'b1;
        state_nxt  = S_SCALE;
      end
      S_SCALE: begin
        scaled_nxt = 18'(amp_prod >>> 15);
        state_nxt  = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          if (mix_sum > 19'sd32767) begin
            out_data_nxt.sample_out = 16'sh7FFF;
            out_data_nxt.saturated  = 1'b1;
          end else if (mix_sum < -19'sd32768) begin
            out_data_nxt.sample_out = 16'sh8000;
            out_data_nxt.saturated  = 1'b1;
          end else begin
            out_data_nxt.sample_out = mix_sum[SMP_W-1:0];
            out_data_nxt.saturated  = 1'b0;
          end
          state_nxt = S_WRAP;
        end
      end
      S_WRAP: begin
        if (!wrap_busy) begin
          phase_nxt = wrap_result;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r      <= job_nxt;
    a_r        <= a_nxt;
    mul_r      <= mul_nxt;
    interp_r   <= interp_nxt;
    scaled_r   <= scaled_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= job.value;
    end
    rd_data_r <= mem[rd_addr];
  end

endmodule

/* rtl/core/wavetable_oscillator_lerp.sv */
// With the back end idle, an accepted render item passes the queue and states IDLE, READ_B,
// INTERP, SCALE and OUT before its sample word is registered on out_data. The back end
// takes one sample word at a time, and no new job until the three-step phase wrap after
// the interpolation and any output stall are over. A two-entry queue sits between front
// and back. Reset (rst_n, synchronous, active low) clears phase, queue, output valid and
// the configuration to base_increment 0 and unity amplitude; the table is not cleared.
module wavetable_oscillator_lerp #(
  parameter int TABLE_LENGTH = 512
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  wol_pkg::in_item_t                  in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output wol_pkg::out_item_t                 out_data,
  input  logic                               cfg_we,
  input  logic [wol_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [wol_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import wol_pkg::*;

  logic [BASE_W-1:0] base_inc_r;
  logic [AMP_W-1:0]  amplitude_r;
  logic              job_valid;
  job_t              job;
  logic              job_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_inc_r  <= BASE_INC_RESET;
      amplitude_r <= AMPLITUDE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BASE_INC:  base_inc_r  <= cfg_data[BASE_W-1:0];
        CFG_AMPLITUDE: amplitude_r <= cfg_data[AMP_W-1:0];
        default: ;
      endcase
    end
  end

  wol_front #(
    .TABLE_LENGTH (TABLE_LENGTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .job_valid (job_valid),
    .job       (job),
    .job_pop   (job_pop)
  );

  wol_back #(
    .TABLE_LENGTH (TABLE_LENGTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (job_valid),
    .job       (job),
    .job_pop   (job_pop),
    .base_inc  (base_inc_r),
    .amplitude (amplitude_r),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
